### design/console_bus_address_decoder_unit_macros.svh
// Assertion macros shared by the console bus address decoder.
`ifndef CONSOLE_BUS_ADDRESS_DECODER_UNIT_MACROS_SVH
`define CONSOLE_BUS_ADDRESS_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CBAD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CBAD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/cbad_pkg.sv
// Types, constants and helper functions of the console bus address decoder.
package cbad_pkg;

    localparam int RAM_WORDS        = 2048;
    localparam int NAME_TABLE_WORDS = 1024;
    localparam int CART_WORDS       = 49120;
    localparam int PATTERN_WORDS    = 8192;
    localparam int PALETTE_WORDS    = 32;
    localparam int AUDIO_WORDS      = 23;
    localparam int VIDEO_REG_WORDS  = 8;

    localparam int RAM_AW        = $clog2(RAM_WORDS);
    localparam int CPU_MEM_WORDS = RAM_WORDS + CART_WORDS;
    localparam int CPU_AW        = $clog2(CPU_MEM_WORDS);
    localparam int VID_MEM_WORDS = PATTERN_WORDS + 4 * NAME_TABLE_WORDS + PALETTE_WORDS;
    localparam int VID_AW        = $clog2(VID_MEM_WORDS);
    localparam int NT_AW         = $clog2(4 * NAME_TABLE_WORDS);
    localparam int AUDIO_AW      = $clog2(AUDIO_WORDS);

    localparam logic [15:0] VIDEO_REG_BASE = 16'h2000;
    localparam logic [15:0] AUDIO_BASE     = 16'h4000;
    localparam logic [15:0] ZERO_REG_LO    = 16'h4017;
    localparam logic [15:0] ZERO_REG_HI    = 16'h4018;
    localparam logic [15:0] CART_BASE      = 16'h4020;
    localparam logic [15:0] PALETTE_BASE   = 16'h3F00;

    typedef enum logic [2:0] {
        OP_CPU_READ    = 3'd0,
        OP_CPU_WRITE   = 3'd1,
        OP_VID_READ    = 3'd2,
        OP_VID_WRITE   = 3'd3,
        OP_ADD_CYCLES  = 3'd4,
        OP_CLEAR_CYCLES = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        SRC_NONE      = 3'd0,
        SRC_CPU_MEM   = 3'd1,
        SRC_VID_MEM   = 3'd2,
        SRC_VIDEO_REG = 3'd3,
        SRC_AUDIO_REG = 3'd4,
        SRC_SPARE     = 3'd5
    } source_t;

    typedef enum logic [2:0] {
        EV_CONTROL = 3'd0,
        EV_MASK    = 3'd1,
        EV_SCROLL  = 3'd2,
        EV_ADDRESS = 3'd3,
        EV_DATA    = 3'd4
    } event_kind_t;

    typedef struct packed {
        source_t             src;
        logic                is_write;
        logic [CPU_AW-1:0]   cpu_addr;
        logic [VID_AW-1:0]   vid_addr;
        logic [AUDIO_AW-1:0] reg_idx;
        logic                ev_valid;
        event_kind_t         ev_kind;
        logic                count_add;
        logic                count_clear;
    } decode_t;

    // Work RAM mirror: the address is below four times the RAM size.
    function automatic logic [RAM_AW-1:0] ram_index(input logic [12:0] a);
        logic [15:0] w;
        w = {3'b000, a};
        if (w >= 16'(3 * RAM_WORDS)) begin
            w = w - 16'(3 * RAM_WORDS);
        end
        else if (w >= 16'(2 * RAM_WORDS)) begin
            w = w - 16'(2 * RAM_WORDS);
        end
        else if (w >= 16'(RAM_WORDS)) begin
            w = w - 16'(RAM_WORDS);
        end
        return w[RAM_AW-1:0];
    endfunction

endpackage

### design/cbad_ram.sv
// Single-port synchronous RAM with a registered read port.
module cbad_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/cbad_decode.sv
// Address decoder for the CPU and video buses; it also flags the cycle-count commands.
module cbad_decode (
    input  logic [2:0]       op,
    input  logic [15:0]      address,
    output cbad_pkg::decode_t dec
);

    logic [15:0] cart_off;

    assign cart_off = address - cbad_pkg::CART_BASE + 16'(cbad_pkg::RAM_WORDS);

    always_comb
    begin
        dec             = '0;
        dec.src         = cbad_pkg::SRC_NONE;
        dec.ev_kind     = cbad_pkg::EV_CONTROL;
        case (op)
            cbad_pkg::OP_CPU_READ, cbad_pkg::OP_CPU_WRITE:
            begin
                dec.is_write = (op == cbad_pkg::OP_CPU_WRITE);
                if (address < cbad_pkg::VIDEO_REG_BASE)
                begin
                    dec.src      = cbad_pkg::SRC_CPU_MEM;
                    dec.cpu_addr = cbad_pkg::CPU_AW'(cbad_pkg::ram_index(address[12:0]));
                end
                else if (address < cbad_pkg::AUDIO_BASE)
                begin
                    dec.src     = cbad_pkg::SRC_VIDEO_REG;
                    dec.reg_idx = cbad_pkg::AUDIO_AW'(address[2:0]);
                    if (dec.is_write)
                    begin
                        case (address[2:0])
                            3'd0:
                            begin
                                dec.ev_valid = 1'b1;
                                dec.ev_kind  = cbad_pkg::EV_CONTROL;
                            end
                            3'd1:
                            begin
                                dec.ev_valid = 1'b1;
                                dec.ev_kind  = cbad_pkg::EV_MASK;
                            end
                            3'd5:
                            begin
                                dec.ev_valid = 1'b1;
                                dec.ev_kind  = cbad_pkg::EV_SCROLL;
                            end
                            3'd6:
                            begin
                                dec.ev_valid = 1'b1;
                                dec.ev_kind  = cbad_pkg::EV_ADDRESS;
                            end
                            3'd7:
                            begin
                                dec.ev_valid = 1'b1;
                                dec.ev_kind  = cbad_pkg::EV_DATA;
                            end
                            default:
                            begin
                                dec.ev_valid = 1'b0;
                            end
                        endcase
                    end
                end
                else if (address < cbad_pkg::ZERO_REG_LO)
                begin
                    dec.src     = cbad_pkg::SRC_AUDIO_REG;
                    dec.reg_idx = address[cbad_pkg::AUDIO_AW-1:0];
                end
                else if (address == cbad_pkg::ZERO_REG_LO || address == cbad_pkg::ZERO_REG_HI)
                begin
                    dec.src = cbad_pkg::SRC_NONE;
                end
                else if (address < cbad_pkg::CART_BASE)
                begin
                    dec.src = cbad_pkg::SRC_SPARE;
                end
                else
                begin
                    dec.src      = cbad_pkg::SRC_CPU_MEM;
                    dec.cpu_addr = cbad_pkg::CPU_AW'(cart_off);
                end
            end
            cbad_pkg::OP_VID_READ, cbad_pkg::OP_VID_WRITE:
            begin
                dec.is_write = (op == cbad_pkg::OP_VID_WRITE);
                if (address < cbad_pkg::VIDEO_REG_BASE)
                begin
                    dec.src      = cbad_pkg::SRC_VID_MEM;
                    dec.vid_addr = cbad_pkg::VID_AW'(address[12:0]);
                end
                else if (address < cbad_pkg::PALETTE_BASE)
                begin
                    dec.src      = cbad_pkg::SRC_VID_MEM;
                    dec.vid_addr = cbad_pkg::VID_AW'(cbad_pkg::PATTERN_WORDS)
                                   + cbad_pkg::VID_AW'(address[cbad_pkg::NT_AW-1:0]);
                end
                else if (address < cbad_pkg::AUDIO_BASE)
                begin
                    dec.src      = cbad_pkg::SRC_VID_MEM;
                    dec.vid_addr = cbad_pkg::VID_AW'(cbad_pkg::PATTERN_WORDS
                                   + 4 * cbad_pkg::NAME_TABLE_WORDS)
                                   + cbad_pkg::VID_AW'(address[4:0]);
                end
                else
                begin
                    dec.src = cbad_pkg::SRC_SPARE;
                end
            end
            cbad_pkg::OP_ADD_CYCLES:
            begin
                dec.count_add = 1'b1;
            end
            cbad_pkg::OP_CLEAR_CYCLES:
            begin
                dec.count_clear = 1'b1;
            end
            default:
            begin
                dec.src = cbad_pkg::SRC_NONE;
            end
        endcase
    end

endmodule

### design/console_bus_address_decoder_unit.sv
// Top level of the console bus address decoder.
// The block takes one command in every clock cycle and never raises busy. The result of a
// command is on the result ports, marked by done, in the cycle after start, for that cycle
// alone; the receiver must take it then. That follows from the registered read of the two
// store memories, one for the CPU bus and one for the video bus. Video register snapshots
// and the cycle count in an event show the state left by the write that raised it.
`include "console_bus_address_decoder_unit_macros.svh"
module console_bus_address_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  cycle_amount,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        event_valid,
    output logic [2:0]  event_kind,
    output logic [7:0]  snap_control,
    output logic [7:0]  snap_mask,
    output logic [7:0]  snap_sprite_addr,
    output logic [7:0]  snap_sprite_data,
    output logic [7:0]  snap_vram_addr,
    output logic [7:0]  snap_vram_data,
    output logic [7:0]  snap_scroll,
    output logic [15:0] event_cycle
);

    cbad_pkg::decode_t dec;
    logic              accept;
    logic              cpu_en;
    logic              vid_en;
    logic [7:0]        cpu_rdata;
    logic [7:0]        vid_rdata;

    logic [7:0]        video_regs_reg [cbad_pkg::VIDEO_REG_WORDS];
    logic [7:0]        audio_regs_reg [cbad_pkg::AUDIO_WORDS];
    logic [7:0]        spare_reg;
    logic [15:0]       cycle_count_reg;

    logic                         done_reg;
    cbad_pkg::source_t            rd_src_reg;
    logic [cbad_pkg::AUDIO_AW-1:0] rd_idx_reg;
    logic                         ev_valid_reg;
    cbad_pkg::event_kind_t        ev_kind_reg;
    logic                         store_write;
    logic                         clear_accept;
    logic                         ctrl_write;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cbad_decode u_decode (
        .op      (op),
        .address (address),
        .dec     (dec)
    );

    assign cpu_en = accept && (dec.src == cbad_pkg::SRC_CPU_MEM);
    assign vid_en = accept && (dec.src == cbad_pkg::SRC_VID_MEM);

    cbad_ram #(
        .DEPTH (cbad_pkg::CPU_MEM_WORDS),
        .WIDTH (8)
    ) u_cpu_mem (
        .clk   (clk),
        .en    (cpu_en),
        .we    (dec.is_write),
        .addr  (dec.cpu_addr),
        .wdata (write_data),
        .rdata (cpu_rdata)
    );

    cbad_ram #(
        .DEPTH (cbad_pkg::VID_MEM_WORDS),
        .WIDTH (8)
    ) u_vid_mem (
        .clk   (clk),
        .en    (vid_en),
        .we    (dec.is_write),
        .addr  (dec.vid_addr),
        .wdata (write_data),
        .rdata (vid_rdata)
    );

    assign store_write = accept && dec.is_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbad_pkg::VIDEO_REG_WORDS; i++)
            begin
                video_regs_reg[i] <= '0;
            end
            for (int i = 0; i < cbad_pkg::AUDIO_WORDS; i++)
            begin
                audio_regs_reg[i] <= '0;
            end
            spare_reg       <= '0;
            cycle_count_reg <= '0;
        end
        else
        begin
            if (store_write && dec.src == cbad_pkg::SRC_VIDEO_REG)
            begin
                video_regs_reg[dec.reg_idx[2:0]] <= write_data;
            end
            if (store_write && dec.src == cbad_pkg::SRC_AUDIO_REG)
            begin
                audio_regs_reg[dec.reg_idx] <= write_data;
            end
            if (store_write && dec.src == cbad_pkg::SRC_SPARE)
            begin
                spare_reg <= write_data;
            end
            if (accept && dec.count_add)
            begin
                cycle_count_reg <= cycle_count_reg + {8'h00, cycle_amount};
            end
            else if (accept && dec.count_clear)
            begin
                cycle_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            rd_src_reg   <= cbad_pkg::SRC_NONE;
            rd_idx_reg   <= '0;
            ev_valid_reg <= 1'b0;
            ev_kind_reg  <= cbad_pkg::EV_CONTROL;
        end
        else
        begin
            done_reg     <= accept;
            rd_src_reg   <= dec.is_write ? cbad_pkg::SRC_NONE : dec.src;
            rd_idx_reg   <= dec.reg_idx;
            ev_valid_reg <= accept && dec.ev_valid;
            ev_kind_reg  <= dec.ev_kind;
        end
    end

    always_comb
    begin
        read_data = '0;
        if (done_reg)
        begin
            case (rd_src_reg)
                cbad_pkg::SRC_CPU_MEM:   read_data = cpu_rdata;
                cbad_pkg::SRC_VID_MEM:   read_data = vid_rdata;
                cbad_pkg::SRC_VIDEO_REG: read_data = video_regs_reg[rd_idx_reg[2:0]];
                cbad_pkg::SRC_AUDIO_REG: read_data = audio_regs_reg[rd_idx_reg];
                cbad_pkg::SRC_SPARE:     read_data = spare_reg;
                default:                 read_data = '0;
            endcase
        end
    end

    assign done             = done_reg;
    assign event_valid      = ev_valid_reg;
    assign event_kind       = ev_valid_reg ? ev_kind_reg : 3'd0;
    assign snap_control     = ev_valid_reg ? video_regs_reg[0] : 8'd0;
    assign snap_mask        = ev_valid_reg ? video_regs_reg[1] : 8'd0;
    assign snap_sprite_addr = ev_valid_reg ? video_regs_reg[3] : 8'd0;
    assign snap_sprite_data = ev_valid_reg ? video_regs_reg[4] : 8'd0;
    assign snap_scroll      = ev_valid_reg ? video_regs_reg[5] : 8'd0;
    assign snap_vram_addr   = ev_valid_reg ? video_regs_reg[6] : 8'd0;
    assign snap_vram_data   = ev_valid_reg ? video_regs_reg[7] : 8'd0;
    assign event_cycle      = ev_valid_reg ? cycle_count_reg : 16'd0;

    assign clear_accept = accept && op == cbad_pkg::OP_CLEAR_CYCLES;
    assign ctrl_write   = accept && op == cbad_pkg::OP_CPU_WRITE && address[15:13] == 3'b001
                          && address[2:0] == 3'd0;

    `CBAD_ASSERT_IMPLIES(a_event_in_result, clk, rst_n, event_valid, done && read_data == 8'd0)
    `CBAD_ASSERT_NEXT(a_clear_count, clk, rst_n, clear_accept, cycle_count_reg == 16'd0)
    `CBAD_ASSERT_NEXT(a_one_result, clk, rst_n, accept, done)
    `CBAD_ASSERT_NEXT(a_ctrl_event, clk, rst_n, ctrl_write, event_valid)
    `CBAD_ASSERT_NEXT(a_snap_ctrl, clk, rst_n, ctrl_write, snap_control == $past(write_data))

endmodule
